>>> hw/rtl/rgb_box_filter_3x3_core_macros.svh
// Assertion macros for the RGB 3x3 box filter checker.
// Each macro expects clk and rst_n in scope; no other dependencies.
`ifndef RGB_BOX_FILTER_3X3_CORE_MACROS_SVH
`define RGB_BOX_FILTER_3X3_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define RGBBF_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rgbbf assertion failed");

// Next-cycle implication, disabled during reset
`define RGBBF_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rgbbf assertion failed");

`endif

>>> hw/rtl/rgbbf_pkg.sv
// Shared types, constants and helper functions for the RGB 3x3 box filter.
// No dependencies.
package rgbbf_pkg;

    // Line store depth and derived column counter width
    localparam int MAX_LINE     = 2048;
    localparam int COL_W        = $clog2(MAX_LINE);

    // Field and register widths
    localparam int SAMPLE_W     = 8;
    localparam int QUOT_W       = 5;
    localparam int SUM_W        = 8;
    localparam int WIDTH_REG_W  = 12;
    localparam int HEIGHT_REG_W = 16;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_INDEX_W  = 1;
    localparam int MIN_DIM      = 3;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    // Reset values
    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 12'd640;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 16'd480;

    // floor(x/9) for 8-bit x as (x*57)>>9, exact over 0..255
    localparam int DIV9_MUL   = 57;
    localparam int DIV9_SHIFT = 9;
    localparam int DIV9_PW    = SAMPLE_W + 6;

    typedef struct packed {
        logic [SAMPLE_W-1:0] blue;
        logic [SAMPLE_W-1:0] green;
        logic [SAMPLE_W-1:0] red;
    } pixel_t;

    // One line store entry: pixel two lines up and one line up
    typedef struct packed {
        pixel_t upper;
        pixel_t lower;
    } line_entry_t;

    typedef struct packed {
        logic [QUOT_W-1:0] blue;
        logic [QUOT_W-1:0] green;
        logic [QUOT_W-1:0] red;
    } qpixel_t;

    function automatic logic [QUOT_W-1:0] div9(input logic [SAMPLE_W-1:0] x);
        logic [DIV9_PW-1:0] prod;
        prod = DIV9_PW'(x) * DIV9_PW'(DIV9_MUL);
        return prod[DIV9_SHIFT +: QUOT_W];
    endfunction

    function automatic qpixel_t div9_pixel(input pixel_t p);
        qpixel_t q;
        q.red   = div9(p.red);
        q.green = div9(p.green);
        q.blue  = div9(p.blue);
        return q;
    endfunction

endpackage

>>> hw/rtl/rgb_box_filter_3x3_core.sv
// Top level of the streaming RGB 3x3 box filter.
// Depends on rgbbf_pkg, rgbbf_line_buf and rgbbf_window.
//
// Takes one RGB pixel per clock in raster order and returns the cropped
// (width-2) x (height-2) image, each channel the sum of floor(tap/9) over the
// 3x3 neighborhood; tlast marks the frame's last result. A request is taken
// every cycle while the output side keeps up; results pass through stage 1,
// fed by the registered read of the single line store memory, and then the
// output register. Width is clamped to 3..2048 and height to at least 3.
// Writing either register restarts the frame (line contents are kept); write
// only while the block is empty.
module rgb_box_filter_3x3_core
    import rgbbf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [23:0]            s_axis_tdata,   // red_in, green_in, blue_in
    // output stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [23:0]            m_axis_tdata,   // red_out, green_out, blue_out
    output logic                   m_axis_tlast    // frame_end
);

    // Configuration registers
    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;
    logic                    cfg_restart;

    assign cfg_restart = cfg_we;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data[WIDTH_REG_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= cfg_data[HEIGHT_REG_W-1:0];
                default:          ;
            endcase
        end
    end

    // Last column and last row after clamping
    logic [COL_W-1:0]        col_last;
    logic [HEIGHT_REG_W-1:0] row_last;

    always_comb
    begin
        if (32'(width_reg) < MIN_DIM)
        begin
            col_last = COL_W'(MIN_DIM - 1);
        end
        else if (32'(width_reg) > MAX_LINE)
        begin
            col_last = COL_W'(MAX_LINE - 1);
        end
        else
        begin
            col_last = COL_W'(width_reg - 1'b1);
        end

        if (32'(height_reg) < MIN_DIM)
        begin
            row_last = HEIGHT_REG_W'(MIN_DIM - 1);
        end
        else
        begin
            row_last = height_reg - 1'b1;
        end
    end

    // Handshake and stage control
    logic s1_valid_reg, s1_valid_next;
    logic s1_prod_reg;
    logic s1_last_reg;
    logic out_valid_reg, out_valid_next;
    logic s1_adv;
    logic in_acc;

    assign s1_adv        = s1_valid_reg && (!s1_prod_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_adv;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // Position counters
    logic [COL_W-1:0]        col_reg, col_next;
    logic [HEIGHT_REG_W-1:0] row_reg, row_next;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_restart)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (in_acc)
        begin
            if (col_reg == col_last)
            begin
                col_next = '0;
                row_next = (row_reg == row_last) ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Stage 1: incoming pixel, column and result flags
    pixel_t           s1_pix_reg;
    logic [COL_W-1:0] s1_col_reg;

    assign s1_valid_next = in_acc || (s1_valid_reg && !s1_adv);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_pix_reg  <= pixel_t'(s_axis_tdata);
            s1_col_reg  <= col_reg;
            s1_prod_reg <= (row_reg >= 2) && (col_reg >= 2);
            s1_last_reg <= (row_reg == row_last) && (col_reg == col_last);
        end
    end

    // Line store: read at accept, written back when stage 1 moves on
    line_entry_t rd_entry;
    line_entry_t wr_entry;

    assign wr_entry.upper = rd_entry.lower;
    assign wr_entry.lower = s1_pix_reg;

    rgbbf_line_buf u_line_buf (
        .clk     (clk),
        .rd_en   (in_acc),
        .rd_addr (col_reg),
        .rd_data (rd_entry),
        .wr_en   (s1_adv),
        .wr_addr (s1_col_reg),
        .wr_data (wr_entry)
    );

    // Window and sum
    pixel_t sum_px;

    rgbbf_window u_window (
        .clk    (clk),
        .rst_n  (rst_n),
        .clear  (cfg_restart),
        .shift  (s1_adv),
        .top_px (rd_entry.upper),
        .mid_px (rd_entry.lower),
        .bot_px (s1_pix_reg),
        .sum_px (sum_px)
    );

    // Output register
    pixel_t out_pix_reg;
    logic   out_last_reg;
    logic   out_load;

    assign out_load       = s1_adv && s1_prod_reg;
    assign out_valid_next = out_load || (out_valid_reg && !m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_pix_reg  <= sum_px;
            out_last_reg <= s1_last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_pix_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

>>> hw/rtl/rgbbf_line_buf.sv
// Two-line pixel store as one memory, one write and one registered read port.
// Depends on rgbbf_pkg.
module rgbbf_line_buf
    import rgbbf_pkg::*;
(
    input  logic             clk,
    input  logic             rd_en,
    input  logic [COL_W-1:0] rd_addr,
    output line_entry_t      rd_data,
    input  logic             wr_en,
    input  logic [COL_W-1:0] wr_addr,
    input  line_entry_t      wr_data
);

    line_entry_t mem [MAX_LINE];
    line_entry_t rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read, holds while not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/rgbbf_window.sv
// 3x3 window of pre-divided taps per channel and the nine-tap sum.
// Depends on rgbbf_pkg.
module rgbbf_window
    import rgbbf_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   clear,
    input  logic   shift,
    input  pixel_t top_px,
    input  pixel_t mid_px,
    input  pixel_t bot_px,
    output pixel_t sum_px
);

    // [column 0 oldest][row 0 top]
    qpixel_t win_reg  [2][3];
    qpixel_t win_next [2][3];
    qpixel_t cur_q    [3];

    // Newest column, divided by nine per tap
    always_comb
    begin
        cur_q[0] = div9_pixel(top_px);
        cur_q[1] = div9_pixel(mid_px);
        cur_q[2] = div9_pixel(bot_px);
    end

    // Column shift
    always_comb
    begin
        win_next = win_reg;
        if (clear)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_next[0][r] = '0;
                win_next[1][r] = '0;
            end
        end
        else if (shift)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_next[0][r] = win_reg[1][r];
                win_next[1][r] = cur_q[r];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[0][r] <= '0;
                win_reg[1][r] <= '0;
            end
        end
        else
        begin
            win_reg <= win_next;
        end
    end

    // Nine-tap sum per channel, at most 252
    always_comb
    begin
        sum_px = '0;
        for (int r = 0; r < 3; r++)
        begin
            sum_px.red   = sum_px.red + SUM_W'(win_reg[0][r].red)
                         + SUM_W'(win_reg[1][r].red) + SUM_W'(cur_q[r].red);
            sum_px.green = sum_px.green + SUM_W'(win_reg[0][r].green)
                         + SUM_W'(win_reg[1][r].green) + SUM_W'(cur_q[r].green);
            sum_px.blue  = sum_px.blue + SUM_W'(win_reg[0][r].blue)
                         + SUM_W'(win_reg[1][r].blue) + SUM_W'(cur_q[r].blue);
        end
    end

endmodule

>>> hw/rtl/rgbbf_checker.sv
// Port-level checker for the RGB 3x3 box filter, bound to the top level.
// Depends on rgbbf_pkg and rgb_box_filter_3x3_core_macros.svh.
`include "rgb_box_filter_3x3_core_macros.svh"

module rgbbf_checker
    import rgbbf_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [23:0]            m_axis_tdata,
    input logic                   m_axis_tlast
);

    // A free output side never blocks the input side
    `RGBBF_ASSERT_IMP(a_ready_follows, m_axis_tready, s_axis_tready)

    // Each nine-tap sum stays within 0..252
    `RGBBF_ASSERT_IMP(a_sum_range, m_axis_tvalid,
        (m_axis_tdata[7:0] <= 8'd252) && (m_axis_tdata[15:8] <= 8'd252)
        && (m_axis_tdata[23:16] <= 8'd252))

    // A stalled result holds
    `RGBBF_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

endmodule

bind rgb_box_filter_3x3_core rgbbf_checker u_rgbbf_checker (.*);

>>> sim/tb_top.sv
// Self-checking testbench for rgb_box_filter_3x3_core: streams RGB frames of many sizes
// and checks every filtered pixel against a predictor kept in step with the block.
// Depends on rgbbf_pkg and the rgb_box_filter_3x3_core RTL.
module tb_top
    import rgbbf_pkg::*;
();

    localparam int          TAP_DIVISOR   = 9;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          RANDOM_ITEMS  = 480;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          HOLD_AT_FIRST = 20;
    localparam int          HOLD_AT_NEXT  = 100;
    localparam int unsigned TIMEOUT_TIME  = 6_000_000;

    // One filtered pixel and its end-of-frame flag
    typedef struct packed {
        logic   last;
        pixel_t px;
    } filtered_t;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   cfg_we        = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index     = REG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0]  cfg_data      = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [23:0]            s_axis_tdata  = '0;   // red_in, green_in, blue_in
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [23:0]            m_axis_tdata;         // red_out, green_out, blue_out
    logic                   m_axis_tlast;         // frame_end

    rgb_box_filter_3x3_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Predictor state: registers, line stores, window and position
    logic [WIDTH_REG_W-1:0]  width_reg  = WIDTH_RESET;
    logic [HEIGHT_REG_W-1:0] height_reg = HEIGHT_RESET;
    pixel_t                  upper_line [MAX_LINE];
    pixel_t                  lower_line [MAX_LINE];
    pixel_t                  win_cols [2][3];   // [0 oldest][row 0 top]
    int unsigned             col_pos    = 0;
    int unsigned             row_pos    = 0;

    pixel_t      pending_pixels [$];
    filtered_t   filtered_due [$];
    int unsigned burst_left    = 1;
    int unsigned gap_left      = 0;
    int unsigned hold_left     = 0;
    int unsigned stall_mode    = 0;
    logic [7:0]  stall_mask    = 8'hA5;
    int unsigned recv_cycles   = 0;
    int unsigned pixels_sent   = 0;
    int unsigned results_seen  = 0;
    int unsigned frames_closed = 0;
    int unsigned cfg_writes    = 0;
    int unsigned error_count   = 0;

    initial
    begin
        for (int i = 0; i < MAX_LINE; i++)
        begin
            upper_line[i] = '0;
            lower_line[i] = '0;
        end
        for (int c = 0; c < 2; c++)
            for (int r = 0; r < 3; r++)
                win_cols[c][r] = '0;
    end

    function automatic int unsigned eff_width();
        int unsigned w;
        w = width_reg;
        if (w < MIN_DIM) w = MIN_DIM;
        if (w > MAX_LINE) w = MAX_LINE;
        return w;
    endfunction

    function automatic int unsigned eff_height();
        int unsigned h;
        h = height_reg;
        if (h < MIN_DIM) h = MIN_DIM;
        return h;
    endfunction

    // Advance the predictor by one pixel; queue a result for interior positions
    function automatic void box_filter_step(pixel_t px_in);
        int unsigned w;
        int unsigned h;
        int unsigned col;
        int unsigned acc;
        pixel_t      column_now [3];
        filtered_t   res;
        w   = eff_width();
        h   = eff_height();
        col = col_pos;
        if (col >= w) col = w - 1;
        column_now[0] = upper_line[col];
        column_now[1] = lower_line[col];
        column_now[2] = px_in;

        if (row_pos >= 2 && col >= 2)
        begin
            for (int k = 0; k < 3; k++)
            begin
                acc = 0;
                for (int r = 0; r < 3; r++)
                begin
                    acc += win_cols[0][r][8*k +: 8] / TAP_DIVISOR;
                    acc += win_cols[1][r][8*k +: 8] / TAP_DIVISOR;
                    acc += column_now[r][8*k +: 8] / TAP_DIVISOR;
                end
                res.px[8*k +: 8] = acc[7:0];
            end
            res.last = (row_pos == h - 1) && (col == w - 1);
            filtered_due.push_back(res);
        end

        upper_line[col] = column_now[1];
        lower_line[col] = column_now[2];
        for (int r = 0; r < 3; r++)
        begin
            win_cols[0][r] = win_cols[1][r];
            win_cols[1][r] = column_now[r];
        end

        if (col + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
        end
        else
        begin
            col_pos = col + 1;
        end
    endfunction

    function automatic void check_field(string field, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            error_count++;
        end
    endfunction

    // Samples biased toward extremes, multiples of nine and the values just below them
    function automatic logic [7:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'(TAP_DIVISOR * $urandom_range(1, 28) - $urandom_range(0, 1));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic queue_pixels(input int unsigned count);
        pixel_t px;
        for (int unsigned i = 0; i < count; i++)
        begin
            px.red   = pick_sample();
            px.green = pick_sample();
            px.blue  = pick_sample();
            pending_pixels.push_back(px);
        end
    endtask

    // Register write; the predictor restarts its frame as the block does
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx == REG_IMAGE_WIDTH)
            width_reg = value[WIDTH_REG_W-1:0];
        else
            height_reg = value[HEIGHT_REG_W-1:0];
        col_pos = 0;
        row_pos = 0;
        for (int c = 0; c < 2; c++)
            for (int r = 0; r < 3; r++)
                win_cols[c][r] = '0;
        cfg_writes++;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Wait until every pixel is taken and every result has arrived
    task automatic drain();
        while (pending_pixels.size() != 0 || s_axis_tvalid || filtered_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Sender: offers queued pixels in bursts with random gaps
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                box_filter_step(pending_pixels.pop_front());
                pixels_sent++;
            end
            // a request not yet taken stays up unchanged
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_pixels.size() != 0)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pending_pixels[0];
                    if (burst_left > 1)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 48);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                    end
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks results in order and stalls on its own pattern
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (filtered_due.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual data %h last %b",
                             $time, m_axis_tdata, m_axis_tlast);
                    error_count++;
                end
                else
                begin
                    check_field("red_out", filtered_due[0].px.red, m_axis_tdata[7:0]);
                    check_field("green_out", filtered_due[0].px.green, m_axis_tdata[15:8]);
                    check_field("blue_out", filtered_due[0].px.blue, m_axis_tdata[23:16]);
                    check_field("frame_end", filtered_due[0].last, m_axis_tlast);
                    void'(filtered_due.pop_front());
                end
                results_seen++;
                if (m_axis_tlast) frames_closed++;
                // long hold-off so the block backs up into its input
                if (results_seen == HOLD_AT_FIRST || results_seen == HOLD_AT_NEXT)
                    hold_left = HOLD_CYCLES;
            end

            recv_cycles++;
            if (recv_cycles % 97 == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_mask = 8'($urandom);
            end

            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                case (stall_mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= 1'($urandom_range(0, 1));
                    2:
                    begin
                        stall_mask = {stall_mask[6:0], stall_mask[7]};
                        m_axis_tready <= stall_mask[0];
                    end
                    default: m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Stimulus sequence
    initial
    begin
        int unsigned w_val;
        int unsigned h_val;
        int unsigned frame_px;
        int unsigned n;
        int unsigned sel;
        int unsigned random_items;
        pixel_t      mixed_frame [9];

        random_items = 0;
        mixed_frame  = '{24'h000000, 24'h0908FF, 24'h121100, 24'hFCFB1B, 24'h00FF00,
                         24'hFF00FF, 24'h1A242D, 24'h3F4809, 24'h0800FE};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reset geometry: start of the first 640-pixel line, no results yet
        queue_pixels(40);
        drain();

        // low registers clamp to 3x3; saturated frame, mixed frame, then a partial one
        write_reg(REG_IMAGE_WIDTH, 16'd1);
        write_reg(REG_IMAGE_HEIGHT, 16'd2);
        for (int i = 0; i < 9; i++)
            pending_pixels.push_back(24'hFFFFFF);
        for (int i = 0; i < 9; i++)
            pending_pixels.push_back(mixed_frame[i]);
        queue_pixels(5);
        drain();

        // two 8x6 frames in one stream; the receiver holds off partway through
        write_reg(REG_IMAGE_WIDTH, 16'd8);
        write_reg(REG_IMAGE_HEIGHT, 16'd6);
        queue_pixels(2 * 8 * 6);
        drain();

        // oversized and near-maximum widths, start of the first line only
        write_reg(REG_IMAGE_WIDTH, 16'd4095);
        write_reg(REG_IMAGE_HEIGHT, 16'd3);
        queue_pixels(40);
        drain();
        write_reg(REG_IMAGE_WIDTH, 16'd2047);
        queue_pixels(40);
        drain();

        // upper width bits are dropped; tallest frame left unfinished
        write_reg(REG_IMAGE_WIDTH, 16'hF004);
        write_reg(REG_IMAGE_HEIGHT, 16'hFFFF);
        queue_pixels(40);
        drain();

        // random geometry, mostly small frames, sometimes cut short by a write
        while (random_items < RANDOM_ITEMS)
        begin
            sel = $urandom_range(0, 9);
            if (sel == 0)
                w_val = $urandom_range(0, 2);
            else if (sel == 1)
                w_val = $urandom_range(11, 48);
            else
                w_val = $urandom_range(3, 10);
            sel = $urandom_range(0, 19);
            if (sel < 3)
                h_val = $urandom_range(0, 2);
            else if (sel == 3)
                h_val = $urandom_range(7, 12);
            else
                h_val = $urandom_range(3, 6);

            case ($urandom_range(0, 3))
                0: write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w_val));
                1: write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h_val));
                2:
                begin
                    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h_val));
                    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w_val));
                end
                default:
                begin
                    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w_val));
                    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h_val));
                end
            endcase

            frame_px = eff_width() * eff_height();
            n = $urandom_range(1, 2) * frame_px;
            if ($urandom_range(0, 3) == 0)
                n += $urandom_range(1, frame_px - 1);
            // keep the total pixel budget
            if (n > RANDOM_ITEMS - random_items)
                n = RANDOM_ITEMS - random_items;
            queue_pixels(n);
            random_items += n;
            drain();
        end

        $display("Sent %0d pixels, checked %0d filtered pixels across %0d frame ends",
                 pixels_sent, results_seen, frames_closed);
        $display("Used %0d register writes (widths 3..2048, heights up to 65535), %0d mismatches",
                 cfg_writes, error_count);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(TIMEOUT_TIME);
        $display("%0t: timeout, %0d results still expected", $time, filtered_due.size());
        $display("TB_ERROR");
        $finish;
    end

endmodule
